[src/kvte_pkg.sv]
// Shared types and codes for the key-value table engine.
// Used by kvte_mem, kvte_seq and key_value_table_engine_top; no dependencies.
`default_nettype none

package kvte_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		FUNC_SET = 2'd0,
		FUNC_GET = 2'd1,
		FUNC_DEL = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] value;
	} result_t;

endpackage

`default_nettype wire

[src/kvte_mem.sv]
// Entry store of the key-value table: one write port and one read port with registered data.
// Depends on kvte_pkg for the entry type.
`default_nettype none

module kvte_mem
	import kvte_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[src/kvte_seq.sv]
// Sequencer of the key-value table: linear search, append, update and shift-down delete,
// all through the single port pair of kvte_mem and one key comparator. Depends on kvte_pkg.
`default_nettype none

module kvte_seq
	import kvte_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request side
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire func_t            req_func,
	input  wire logic [KEY_W-1:0] req_key,
	input  wire logic [VAL_W-1:0] req_value,
	// memory side
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output entry_t                mem_wdata,
	output logic [AW-1:0]         mem_raddr,
	input  wire entry_t           mem_rdata,
	// result side
	output logic                  res_valid,
	input  wire logic             res_ready,
	output result_t               res
);

	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	state_t           state_q, state_d;
	logic [CW-1:0]    used_q, used_d;
	logic [CW-1:0]    idx_q, idx_d;          // next read address, in search and in shift
	logic [AW-1:0]    cmp_idx_q, cmp_idx_d;  // entry under compare, or shift destination
	logic             pend_q, pend_d;        // read data of last cycle is due
	func_t            func_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] wval_q;
	result_t          res_q, res_d;
	logic             match;

	assign match = pend_q && (mem_rdata.key == key_q);
	assign res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			idx_q     <= '0;
			cmp_idx_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			used_q    <= used_d;
			idx_q     <= idx_d;
			cmp_idx_q <= cmp_idx_d;
			pend_q    <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			func_q <= req_func;
			key_q  <= req_key;
			wval_q <= req_value;
		end
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		idx_d     = idx_q;
		cmp_idx_d = cmp_idx_q;
		pend_d    = pend_q;
		res_d     = res_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cmp_idx_q;
		mem_wdata = '{value: wval_q, key: key_q};
		mem_raddr = idx_q[AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					idx_d   = '0;
					pend_d  = 1'b0;
					state_d = S_SCAN;
				end
			end

			S_SCAN: begin
				if (match) begin
					// Only the first match counts; the search stops here.
					pend_d = 1'b0;
					res_d  = '{status: ST_OK, value: '0};
					priority if (func_q == FUNC_SET) begin
						mem_we  = 1'b1;
						state_d = S_DONE;
					end else if (func_q == FUNC_GET) begin
						res_d.value = mem_rdata.value;
						state_d     = S_DONE;
					end else begin
						// Delete: the found slot becomes the first destination of the shift.
						idx_d   = CW'(cmp_idx_q) + CW'(1);
						state_d = S_SHIFT;
					end
				end else if (idx_q == used_q) begin
					pend_d  = 1'b0;
					state_d = S_DONE;
					if (func_q == FUNC_SET) begin
						if (used_q != FULL_COUNT) begin
							mem_we    = 1'b1;
							mem_waddr = used_q[AW-1:0];
							used_d    = used_q + CW'(1);
							res_d     = '{status: ST_OK, value: '0};
						end else begin
							res_d = '{status: ST_FULL, value: '0};
						end
					end else begin
						res_d = '{status: ST_NOT_FOUND, value: '0};
					end
				end else begin
					cmp_idx_d = idx_q[AW-1:0];
					idx_d     = idx_q + CW'(1);
					pend_d    = 1'b1;
				end
			end

			S_SHIFT: begin
				// Each cycle reads the next entry and writes the one read before one slot lower.
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
					cmp_idx_d = cmp_idx_q + AW'(1);
				end
				if (idx_q != used_q) begin
					idx_d  = idx_q + CW'(1);
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						used_d  = used_q - CW'(1);
						state_d = S_DONE;
					end
				end
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/key_value_table_engine_top.sv]
// Top level of the key-value table engine: stream ports, output register, store and sequencer.
// Depends on kvte_pkg, kvte_mem and kvte_seq.
// A set or get searches the used entries in order up to its key, or through all of them if
// the key is absent; a delete that finds its key then shifts every later entry down one slot.
// One item at a time: the next is taken in the cycle after the result is registered, if
// m_tready allows. After reset the table is empty.
`default_nettype none

module key_value_table_engine_top
	import kvte_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] lookup_key, [63:32] write_value
	input  wire logic [1:0]  s_tuser,   // [1:0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] read_value
	output logic [1:0]       m_tuser    // [1:0] status
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_wdata;
	entry_t        mem_rdata;
	logic          res_valid;
	logic          res_ready;
	result_t       res;
	logic          out_valid_q;
	result_t       out_q;

	kvte_mem #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	kvte_seq #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_func  (func_t'(s_tuser)),
		.req_key   (s_tdata[31:0]),
		.req_value (s_tdata[63:32]),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register lets the sequencer take the next item while a result waits.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.value;
	assign m_tuser  = out_q.status;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for key_value_table_engine_top: stream stimulus, random stalls on
// both sides and a scoreboard that keeps its own copy of the key-value table.
// Depends on kvte_pkg and the engine RTL only.
`default_nettype none

module tb;
	import kvte_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_POOL = 80;
	localparam int RANDOM_ITEMS = 1800;
	localparam int BLOCK_ITEMS = 150;
	localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 20;
	localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused code, behaves as a delete
	localparam int MODE_FILL = 0;
	localparam int MODE_MIXED = 1;
	localparam int MODE_DRAIN = 2;

	class kv_scoreboard;
		logic [KEY_W-1:0] keys [TABLE_ENTRIES];
		logic [VAL_W-1:0] values [TABLE_ENTRIES];
		int unsigned      used;
		result_t          awaited_q [$];
		int unsigned      failures;

		function new();
			used = 0;
			failures = 0;
		endfunction

		function int find_slot(logic [KEY_W-1:0] key);
			for (int i = 0; i < used; i++) begin
				if (keys[i] == key)
					return i;
			end
			return -1;
		endfunction

		// Updates the table copy for one accepted request and queues the result it must give.
		function void note_request(logic [1:0] fn, logic [KEY_W-1:0] key,
				logic [VAL_W-1:0] wval);
			result_t r;
			int      slot;
			slot = find_slot(key);
			r.status = ST_OK;
			r.value = '0;
			if (fn == FUNC_SET) begin
				if (slot >= 0) begin
					values[slot] = wval;
				end else if (used < TABLE_ENTRIES) begin
					keys[used] = key;
					values[used] = wval;
					used++;
				end else begin
					r.status = ST_FULL;
				end
			end else if (fn == FUNC_GET) begin
				if (slot >= 0)
					r.value = values[slot];
				else
					r.status = ST_NOT_FOUND;
			end else begin
				if (slot >= 0) begin
					for (int i = slot; i + 1 < used; i++) begin
						keys[i] = keys[i + 1];
						values[i] = values[i + 1];
					end
					used--;
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			awaited_q.push_back(r);
		endfunction

		function void report(string what, logic [1:0] want_st, logic [VAL_W-1:0] want_val,
				logic [1:0] got_st, logic [VAL_W-1:0] got_val);
			failures++;
			if (failures <= 10)
				$display("%0t: %s: expected status %0d value %h, got status %0d value %h",
					$realtime, what, want_st, want_val, got_st, got_val);
		endfunction

		function void check_result(logic [1:0] got_st, logic [VAL_W-1:0] got_val);
			result_t want;
			if (awaited_q.size() == 0) begin
				report("result with nothing outstanding", 2'd0, '0, got_st, got_val);
				return;
			end
			want = awaited_q.pop_front();
			if (want.status != got_st || want.value != got_val)
				report("result mismatch", want.status, want.value, got_st, got_val);
		endfunction

		function void close_out();
			failures += awaited_q.size();
			if (awaited_q.size() != 0)
				$display("%0d results never arrived", awaited_q.size());
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	kv_scoreboard     sb;
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	key_value_table_engine_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#12ms;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: ready for a while, then stalled for a while, with some long open stretches.
	initial begin
		int open_len;
		int stall_len;
		@(posedge clk);
		wait (arst_n);
		forever begin
			open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (open_len) @(posedge clk);
			stall_len = pick_gap();
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Presents one item and holds it until it is taken; drops valid only if a gap follows.
	task send_request(input logic [1:0] fn, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] wval, input int gap);
		s_tvalid <= 1'b1;
		s_tdata <= {wval, key};
		s_tuser <= fn;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(fn, key, wval);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 92)
			return key_pool[$urandom_range(0, KEY_POOL - 1)];
		return $urandom;
	endfunction

	function logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Operation mix depends on the phase, so the table repeatedly fills up and empties again.
	function logic [1:0] pick_func(int mode);
		int r;
		int set_pct;
		int get_pct;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				set_pct = 85;
				get_pct = 10;
			end
			MODE_DRAIN: begin
				set_pct = 15;
				get_pct = 25;
			end
			default: begin
				set_pct = 40;
				get_pct = 35;
			end
		endcase
		if (r < set_pct)
			return FUNC_SET;
		else if (r < set_pct + get_pct)
			return FUNC_GET;
		return ($urandom_range(0, 9) == 0) ? FUNC_SPARE : FUNC_DEL;
	endfunction

	initial begin
		int mode;
		int quiet;
		sb = new();
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, key and value extremes, update, shift from the front and
		// from the end, the spare code, absent keys and a fully emptied table.
		send_request(FUNC_GET, 32'h0000_0000, 32'h1111_1111, pick_gap());
		send_request(FUNC_DEL, 32'h0000_0000, 32'h0000_0000, pick_gap());
		send_request(FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF, pick_gap());
		send_request(FUNC_SET, 32'h7FFF_FFFF, 32'h8000_0000, pick_gap());
		send_request(FUNC_SET, 32'h0000_0000, 32'hFFFF_FFFF, pick_gap());
		send_request(FUNC_SET, 32'hFFFF_FFFF, 32'h0000_0000, pick_gap());
		send_request(FUNC_GET, 32'h8000_0000, 32'h0000_0000, pick_gap());
		send_request(FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, pick_gap());
		send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000, pick_gap());
		send_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, pick_gap());
		send_request(FUNC_SET, 32'h0000_0000, 32'h1234_5678, pick_gap());
		send_request(FUNC_GET, 32'h0000_0000, 32'hDEAD_BEEF, pick_gap());
		send_request(FUNC_DEL, 32'h8000_0000, 32'hFFFF_FFFF, pick_gap());
		send_request(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, pick_gap());
		send_request(FUNC_SPARE, 32'hFFFF_FFFF, 32'h0000_0000, pick_gap());
		send_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, pick_gap());
		send_request(FUNC_DEL, 32'h5A5A_5A5A, 32'h0000_0000, pick_gap());
		send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000, pick_gap());
		send_request(FUNC_DEL, 32'h7FFF_FFFF, 32'h0000_0000, pick_gap());
		send_request(FUNC_DEL, 32'h0000_0000, 32'h0000_0000, pick_gap());
		send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000, pick_gap());

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % BLOCK_ITEMS == 0) begin
				mode = (n / BLOCK_ITEMS) % 3;
				quiet = ($urandom_range(0, 3) == 0);
			end
			send_request(pick_func(mode), pick_key(), pick_value(), quiet ? 0 : pick_gap());
		end
		s_tvalid <= 1'b0;

		while (sb.awaited_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
